// ===== hw/rtl/aarm_pkg.sv =====
// Shared types, constants and table-building functions for the axis-angle rotation block.
package aarm_pkg;

  localparam int AXIS_W  = 16;
  localparam int ANGLE_W = 9;
  localparam int OUT_W   = 16;
  localparam int OUT_MAX = 32767;
  localparam int OUT_MIN = -32768;

  // Series evaluation format for the sine and cosine table
  localparam int          TAB_FRAC     = 30;
  localparam int          SERIES_DEPTH = 9;
  localparam logic [63:0] ONE_Q30      = 64'd1 << TAB_FRAC;
  localparam logic [63:0] PI_Q30       = 64'd3373259426;

  // Horner divisors, entry k-1 for term k: (2k-1)(2k) and (2k)(2k+1)
  localparam logic [63:0] COS_DIV [SERIES_DEPTH] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182, 64'd240, 64'd306
  };
  localparam logic [63:0] SIN_DIV [SERIES_DEPTH] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
  };

  typedef struct packed {
    logic signed [AXIS_W-1:0]  axis_x;
    logic signed [AXIS_W-1:0]  axis_y;
    logic signed [AXIS_W-1:0]  axis_z;
    logic        [ANGLE_W-1:0] angle_deg;
  } aarm_in_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] m00;
    logic signed [OUT_W-1:0] m01;
    logic signed [OUT_W-1:0] m02;
    logic signed [OUT_W-1:0] m10;
    logic signed [OUT_W-1:0] m11;
    logic signed [OUT_W-1:0] m12;
    logic signed [OUT_W-1:0] m20;
    logic signed [OUT_W-1:0] m21;
    logic signed [OUT_W-1:0] m22;
  } aarm_out_t;

  // Three signed 16-bit components: the axis, later the quaternion vector part
  typedef struct packed {
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] z;
  } aarm_vec_t;

  // Evaluate sin and cos of u (unsigned Q2.30, folded to [0, pi/2]); returns {sin, cos}
  function automatic logic [63:0] tab_sincos(input logic [63:0] u);
    logic [63:0] u2;
    logic [63:0] sn;
    logic [63:0] cs;
    logic [63:0] t;
    logic [63:0] s;
    u2 = (u * u) >> TAB_FRAC;
    sn = ONE_Q30;
    cs = ONE_Q30;
    for (int k = SERIES_DEPTH; k >= 1; k--) begin
      t  = ((u2 * cs) >> TAB_FRAC) / COS_DIV[k-1];
      cs = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
      t  = ((u2 * sn) >> TAB_FRAC) / SIN_DIV[k-1];
      sn = (t >= ONE_Q30) ? 64'd0 : ONE_Q30 - t;
    end
    s = (u * sn) >> TAB_FRAC;
    return {s[31:0], cs[31:0]};
  endfunction

  // Round a non-negative value to nearest, ties up, dropping sh bits
  function automatic logic [63:0] tab_round(input logic [63:0] v, input int sh);
    if (sh == 0) begin
      return v;
    end
    return (v + (64'd1 << (sh - 1))) >> sh;
  endfunction

endpackage

// ===== hw/rtl/aarm_angle.sv =====
// Angle reduction, half-turn fold and sine/cosine table lookup (two stages).
module aarm_angle
  import aarm_pkg::*;
#(
  parameter int FRAC_BITS   = 14,
  parameter int ANGLE_STEPS = 360
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  aarm_in_t                    item,
  output logic                        sc_valid,
  input  logic                        sc_ready,
  output aarm_vec_t                   sc_axis,
  output logic        [FRAC_BITS:0]   sc_sin,
  output logic signed [FRAC_BITS+1:0] sc_cos
);

  localparam int AW        = $clog2(ANGLE_STEPS + 1);
  localparam int ANG_W     = ((AW > ANGLE_W) ? AW : ANGLE_W) + 1;
  localparam int ANGLE_MAX = (1 << ANGLE_W) - 1;
  localparam int MOD_STEPS = ANGLE_MAX / ANGLE_STEPS;
  localparam int TAB_MAX   = (ANGLE_STEPS / 2 < ANGLE_MAX) ? ANGLE_STEPS / 2 : ANGLE_MAX;
  localparam int TAB_DEPTH = TAB_MAX + 1;
  localparam int IW        = $clog2(TAB_DEPTH);

  logic [FRAC_BITS:0] sin_tab [TAB_DEPTH];
  logic [FRAC_BITS:0] cos_tab [TAB_DEPTH];

  // Build the table at elaboration: entry b holds sin and cos of pi*b/ANGLE_STEPS
  for (genvar g = 0; g < TAB_DEPTH; g++) begin : g_tab
    localparam logic [63:0] U   = (PI_Q30 * 64'(g)) / 64'(ANGLE_STEPS);
    localparam logic [63:0] SC  = tab_sincos(U);
    localparam logic [63:0] S_R = tab_round({32'd0, SC[63:32]}, TAB_FRAC - FRAC_BITS);
    localparam logic [63:0] C_R = tab_round({32'd0, SC[31:0]}, TAB_FRAC - FRAC_BITS);
    assign sin_tab[g] = S_R[FRAC_BITS:0];
    assign cos_tab[g] = C_R[FRAC_BITS:0];
  end

  logic                        v1;
  logic [IW-1:0]               idx1;
  logic                        neg1;
  aarm_vec_t                   axis1;
  logic                        v2;
  logic                        en1;
  logic                        en2;
  logic [ANG_W-1:0]            a_red;
  logic                        fold_neg;
  logic [IW-1:0]               fold_idx;
  logic signed [FRAC_BITS+1:0] cos_val;

  assign en2        = !v2 || sc_ready;
  assign en1        = !v1 || en2;
  assign item_ready = en1;
  assign sc_valid   = v2;

  // Reduce the angle code below ANGLE_STEPS, then fold into the first half turn
  always_comb begin
    a_red = ANG_W'(item.angle_deg);
    for (int i = 0; i < MOD_STEPS; i++) begin
      if (a_red >= ANG_W'(ANGLE_STEPS)) begin
        a_red = a_red - ANG_W'(ANGLE_STEPS);
      end
    end
    fold_neg = ({a_red, 1'b0} > (ANG_W + 1)'(ANGLE_STEPS));
    fold_idx = fold_neg ? IW'(ANG_W'(ANGLE_STEPS) - a_red) : IW'(a_red);
  end

  // Stage 1: hold the table index and fold sign
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && item_valid) begin
      idx1  <= fold_idx;
      neg1  <= fold_neg;
      axis1 <= '{x: item.axis_x, y: item.axis_y, z: item.axis_z};
    end
  end

  // Stage 2: read the table and restore the sign of cos
  assign cos_val = $signed({1'b0, cos_tab[idx1]});

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      sc_axis <= axis1;
      sc_sin  <= sin_tab[idx1];
      sc_cos  <= neg1 ? -cos_val : cos_val;
    end
  end

endmodule

// ===== hw/rtl/aarm_quat.sv =====
// Quaternion stage: scale the axis by sin of the half angle, pass cos through as w.
module aarm_quat
  import aarm_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sc_valid,
  output logic                        sc_ready,
  input  aarm_vec_t                   sc_axis,
  input  logic        [FRAC_BITS:0]   sc_sin,
  input  logic signed [FRAC_BITS+1:0] sc_cos,
  output logic                        q_valid,
  input  logic                        q_ready,
  output aarm_vec_t                   q_vec,
  output logic signed [FRAC_BITS+1:0] q_w
);

  localparam int PROD_W = FRAC_BITS + AXIS_W + 2;
  localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (FRAC_BITS - 1);

  logic                     v3;
  logic                     en3;
  logic signed [PROD_W-1:0] sin_s;
  logic signed [PROD_W-1:0] px;
  logic signed [PROD_W-1:0] py;
  logic signed [PROD_W-1:0] pz;
  logic signed [PROD_W-1:0] rx;
  logic signed [PROD_W-1:0] ry;
  logic signed [PROD_W-1:0] rz;

  assign en3      = !v3 || q_ready;
  assign sc_ready = en3;
  assign q_valid  = v3;

  // Multiply and round to FRAC_BITS; the result always fits 16 bits
  assign sin_s = PROD_W'($signed({1'b0, sc_sin}));
  assign px    = PROD_W'(sc_axis.x) * sin_s;
  assign py    = PROD_W'(sc_axis.y) * sin_s;
  assign pz    = PROD_W'(sc_axis.z) * sin_s;
  assign rx    = (px + HALF) >>> FRAC_BITS;
  assign ry    = (py + HALF) >>> FRAC_BITS;
  assign rz    = (pz + HALF) >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= sc_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && sc_valid) begin
      q_vec <= '{x: rx[AXIS_W-1:0], y: ry[AXIS_W-1:0], z: rz[AXIS_W-1:0]};
      q_w   <= sc_cos;
    end
  end

endmodule

// ===== hw/rtl/aarm_mat.sv =====
// Matrix stages: quaternion products, entry sums with rounding, shift and saturation.
module aarm_mat
  import aarm_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  aarm_vec_t                   q_vec,
  input  logic signed [FRAC_BITS+1:0] q_w,
  output logic                        mat_valid,
  input  logic                        mat_ready,
  output aarm_out_t                   mat
);

  localparam int SQ_W   = 2 * AXIS_W;
  localparam int PROD_W = FRAC_BITS + AXIS_W + 2;
  localparam int MAX_A  = (2 * FRAC_BITS > SQ_W) ? 2 * FRAC_BITS : SQ_W;
  localparam int MAX_B  = (MAX_A > FRAC_BITS + AXIS_W + 1) ? MAX_A : FRAC_BITS + AXIS_W + 1;
  localparam int SUMW   = MAX_B + 3;
  localparam logic signed [SUMW-1:0] ONE2   = SUMW'(1) << (2 * FRAC_BITS);
  localparam logic signed [SUMW-1:0] HALF   = SUMW'(1) << (FRAC_BITS - 1);
  localparam logic signed [SUMW-1:0] SAT_HI = SUMW'(OUT_MAX);
  localparam logic signed [SUMW-1:0] SAT_LO = SUMW'(OUT_MIN);

  logic v4;
  logic v5;
  logic v6;
  logic en4;
  logic en5;
  logic en6;

  logic signed [SQ_W-1:0]   p_xx;
  logic signed [SQ_W-1:0]   p_yy;
  logic signed [SQ_W-1:0]   p_zz;
  logic signed [SQ_W-1:0]   p_xy;
  logic signed [SQ_W-1:0]   p_xz;
  logic signed [SQ_W-1:0]   p_yz;
  logic signed [PROD_W-1:0] p_xw;
  logic signed [PROD_W-1:0] p_yw;
  logic signed [PROD_W-1:0] p_zw;

  // Entries in row-major order, m00 first
  logic signed [SUMW-1:0] sum5      [9];
  logic signed [SUMW-1:0] sum5_next [9];

  assign en6       = !v6 || mat_ready;
  assign en5       = !v5 || en6;
  assign en4       = !v4 || en5;
  assign q_ready   = en4;
  assign mat_valid = v6;

  // Shift out the fraction and clamp to the 16-bit range
  function automatic logic signed [OUT_W-1:0] sat16(input logic signed [SUMW-1:0] v);
    logic signed [SUMW-1:0] q;
    q = v >>> FRAC_BITS;
    if (q > SAT_HI) begin
      q = SAT_HI;
    end
    if (q < SAT_LO) begin
      q = SAT_LO;
    end
    return q[OUT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else begin
      if (en4) begin
        v4 <= q_valid;
      end
      if (en5) begin
        v5 <= v4;
      end
      if (en6) begin
        v6 <= v5;
      end
    end
  end

  // Stage 4: all nine pairwise products
  always_ff @(posedge clk) begin
    if (en4 && q_valid) begin
      p_xx <= SQ_W'(q_vec.x) * SQ_W'(q_vec.x);
      p_yy <= SQ_W'(q_vec.y) * SQ_W'(q_vec.y);
      p_zz <= SQ_W'(q_vec.z) * SQ_W'(q_vec.z);
      p_xy <= SQ_W'(q_vec.x) * SQ_W'(q_vec.y);
      p_xz <= SQ_W'(q_vec.x) * SQ_W'(q_vec.z);
      p_yz <= SQ_W'(q_vec.y) * SQ_W'(q_vec.z);
      p_xw <= PROD_W'(q_vec.x) * PROD_W'(q_w);
      p_yw <= PROD_W'(q_vec.y) * PROD_W'(q_w);
      p_zw <= PROD_W'(q_vec.z) * PROD_W'(q_w);
    end
  end

  // Stage 5: combine products into each entry and add the rounding half
  always_comb begin
    sum5_next[0] = ONE2 - ((SUMW'(p_yy) + SUMW'(p_zz)) <<< 1) + HALF;
    sum5_next[1] = ((SUMW'(p_xy) - SUMW'(p_zw)) <<< 1) + HALF;
    sum5_next[2] = ((SUMW'(p_xz) + SUMW'(p_yw)) <<< 1) + HALF;
    sum5_next[3] = ((SUMW'(p_xy) + SUMW'(p_zw)) <<< 1) + HALF;
    sum5_next[4] = ONE2 - ((SUMW'(p_xx) + SUMW'(p_zz)) <<< 1) + HALF;
    sum5_next[5] = ((SUMW'(p_yz) - SUMW'(p_xw)) <<< 1) + HALF;
    sum5_next[6] = ((SUMW'(p_xz) - SUMW'(p_yw)) <<< 1) + HALF;
    sum5_next[7] = ((SUMW'(p_yz) + SUMW'(p_xw)) <<< 1) + HALF;
    sum5_next[8] = ONE2 - ((SUMW'(p_xx) + SUMW'(p_yy)) <<< 1) + HALF;
  end

  always_ff @(posedge clk) begin
    if (en5 && v4) begin
      for (int i = 0; i < 9; i++) begin
        sum5[i] <= sum5_next[i];
      end
    end
  end

  // Stage 6: output register, held while the consumer stalls
  always_ff @(posedge clk) begin
    if (en6 && v5) begin
      mat.m00 <= sat16(sum5[0]);
      mat.m01 <= sat16(sum5[1]);
      mat.m02 <= sat16(sum5[2]);
      mat.m10 <= sat16(sum5[3]);
      mat.m11 <= sat16(sum5[4]);
      mat.m12 <= sat16(sum5[5]);
      mat.m20 <= sat16(sum5[6]);
      mat.m21 <= sat16(sum5[7]);
      mat.m22 <= sat16(sum5[8]);
    end
  end

endmodule

// ===== hw/rtl/axis_angle_rotation_matrix.sv =====
// Top level of the axis-angle to 3x3 rotation matrix pipeline.
// Each input word carries a signed axis (FRAC_BITS fraction bits) and an angle code, where
// ANGLE_STEPS codes make a full turn; codes at or above ANGLE_STEPS wrap. The block forms the
// unit quaternion from sin and cos of half the angle and returns the nine matrix entries,
// row by row, rounded to FRAC_BITS fraction bits and saturated to 16 bits. It takes one word
// per cycle while the output is not stalled, and each result passes through the stages in turn:
// two stages reduce the angle and read a constant sine/cosine table built at elaboration, one
// scales the axis, one forms the nine products, one sums the entries and one rounds,
// saturates and holds the output. Each stage carries its own valid bit and moves whenever
// the stage after it is empty or moving, so a stalled output fills the pipeline's bubbles
// before the input ready drops, and ready is high in every cycle that the output is taken.
module axis_angle_rotation_matrix
  import aarm_pkg::*;
#(
  parameter int FRAC_BITS   = 14,
  parameter int ANGLE_STEPS = 360
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  aarm_in_t  item,
  output logic      mat_valid,
  input  logic      mat_ready,
  output aarm_out_t mat
);

  logic                        sc_valid;
  logic                        sc_ready;
  aarm_vec_t                   sc_axis;
  logic        [FRAC_BITS:0]   sc_sin;
  logic signed [FRAC_BITS+1:0] sc_cos;
  logic                        q_valid;
  logic                        q_ready;
  aarm_vec_t                   q_vec;
  logic signed [FRAC_BITS+1:0] q_w;

  // Angle reduction and table lookup
  aarm_angle #(
    .FRAC_BITS   (FRAC_BITS),
    .ANGLE_STEPS (ANGLE_STEPS)
  ) u_angle (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .sc_valid   (sc_valid),
    .sc_ready   (sc_ready),
    .sc_axis    (sc_axis),
    .sc_sin     (sc_sin),
    .sc_cos     (sc_cos)
  );

  // Quaternion formation
  aarm_quat #(
    .FRAC_BITS (FRAC_BITS)
  ) u_quat (
    .clk      (clk),
    .rst      (rst),
    .sc_valid (sc_valid),
    .sc_ready (sc_ready),
    .sc_axis  (sc_axis),
    .sc_sin   (sc_sin),
    .sc_cos   (sc_cos),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_vec    (q_vec),
    .q_w      (q_w)
  );

  // Matrix entries and output register
  aarm_mat #(
    .FRAC_BITS (FRAC_BITS)
  ) u_mat (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_vec     (q_vec),
    .q_w       (q_w),
    .mat_valid (mat_valid),
    .mat_ready (mat_ready),
    .mat       (mat)
  );

endmodule

// ===== hw/rtl/aarm_chk.sv =====
// Port-level checker for the rotation matrix pipeline, bound to the top level.
module aarm_chk
  import aarm_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input logic      clk,
  input logic      rst,
  input logic      item_valid,
  input logic      item_ready,
  input logic      mat_valid,
  input logic      mat_ready,
  input aarm_out_t mat
);

  localparam int DIAG_MAX = (FRAC_BITS < OUT_W - 1) ? (1 << FRAC_BITS) : OUT_MAX;

  logic [2:0] inflight;

  // Track words accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (rst) begin
      inflight <= 3'd0;
    end else begin
      inflight <= inflight + 3'(item_valid && item_ready) - 3'(mat_valid && mat_ready);
    end
  end

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !mat_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    mat_valid && !mat_ready |=> mat_valid && $stable(mat))
    else $error("stalled result changed or dropped");

  // A consumer that takes every word never stalls the producer
  a_flow: assert property (@(posedge clk) mat_ready |-> item_ready)
    else $error("input stalled while output is taken");

  // No result without an accepted word behind it
  a_no_invent: assert property (@(posedge clk) disable iff (rst)
    mat_valid |-> inflight != 3'd0)
    else $error("result with no word in flight");

  // Diagonal entries are one minus a sum of squares and cannot exceed one
  a_diag: assert property (@(posedge clk) disable iff (rst)
    mat_valid |-> (mat.m00 <= DIAG_MAX) && (mat.m11 <= DIAG_MAX) && (mat.m22 <= DIAG_MAX))
    else $error("diagonal entry above one");

endmodule

bind axis_angle_rotation_matrix aarm_chk #(.FRAC_BITS(FRAC_BITS)) u_aarm_chk (.*);
